/* sv/swcs_pkg.sv */
// ----------------------------------------------------------------------------
// swcs_pkg
// Shared types and constants for the SPIR-V / WGSL compatibility scanner.
// ----------------------------------------------------------------------------
package swcs_pkg;

  typedef enum logic [1:0] {
    VERD_NONE         = 2'd0,
    VERD_INT_WIDTH    = 2'd1,
    VERD_IMAGE_ATOMIC = 2'd2,
    VERD_VIEW_INDEX   = 2'd3
  } verdict_t;

  localparam logic [15:0] OPC_TYPE_INT            = 16'd21;
  localparam logic [15:0] OPC_IMAGE_TEXEL_POINTER = 16'd60;
  localparam logic [15:0] OPC_DECORATE            = 16'd71;
  localparam logic [15:0] OPC_MEMBER_DECORATE     = 16'd72;

  localparam logic [31:0] DECO_BUILT_IN      = 32'd11;
  localparam logic [31:0] BUILTIN_VIEW_INDEX = 32'd4440;
  localparam logic [31:0] INT_WIDTH_OK       = 32'd32;

  localparam logic [2:0] HEADER_WORDS = 3'd5;

  typedef struct packed {
    verdict_t    verdict;
    logic [31:0] bad_int_width;
  } result_t;

endpackage

/* sv/swcs_core.sv */
// ----------------------------------------------------------------------------
// swcs_core
// Scan state and per-word next-state logic; produces the verdict on the
// final word of a module.
// ----------------------------------------------------------------------------
module swcs_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [31:0]       module_word,
  input  logic              final_word,
  output logic              res_valid,
  output swcs_pkg::result_t res
);

  logic [2:0]         header_count, header_count_next;
  logic [15:0]        instr_offset, instr_offset_next;
  logic [15:0]        instr_length, instr_length_next;
  logic [15:0]        instr_opcode, instr_opcode_next;
  logic               deco_builtin, deco_builtin_next;
  swcs_pkg::verdict_t pending_code, pending_code_next;
  logic [31:0]        pending_width, pending_width_next;
  swcs_pkg::verdict_t found_code, found_code_next;
  logic [31:0]        found_width, found_width_next;
  logic               scan_stopped, scan_stopped_next;
  logic [15:0]        offset_inc;

  always_comb begin
    header_count_next  = header_count;
    instr_offset_next  = instr_offset;
    instr_length_next  = instr_length;
    instr_opcode_next  = instr_opcode;
    deco_builtin_next  = deco_builtin;
    pending_code_next  = pending_code;
    pending_width_next = pending_width;
    found_code_next    = found_code;
    found_width_next   = found_width;
    scan_stopped_next  = scan_stopped;
    offset_inc         = instr_offset + 16'd1;

    if (header_count < swcs_pkg::HEADER_WORDS) begin
      header_count_next = header_count + 3'd1;
    end else if (!scan_stopped && found_code == swcs_pkg::VERD_NONE) begin
      if (instr_offset == 16'd0) begin
        instr_length_next = module_word[31:16];
        instr_opcode_next = module_word[15:0];
        if (module_word[31:16] == 16'd0) begin
          scan_stopped_next = 1'b1;
        end else begin
          pending_code_next  = (module_word[15:0] == swcs_pkg::OPC_IMAGE_TEXEL_POINTER) ?
                               swcs_pkg::VERD_IMAGE_ATOMIC : swcs_pkg::VERD_NONE;
          pending_width_next = '0;
          deco_builtin_next  = 1'b0;
        end
      end else begin
        case (instr_opcode)
          swcs_pkg::OPC_TYPE_INT: begin
            if (instr_length >= 16'd3 && instr_offset == 16'd2 &&
                module_word != swcs_pkg::INT_WIDTH_OK) begin
              pending_code_next  = swcs_pkg::VERD_INT_WIDTH;
              pending_width_next = module_word;
            end
          end
          swcs_pkg::OPC_DECORATE: begin
            if (instr_length >= 16'd4) begin
              if (instr_offset == 16'd2) begin
                deco_builtin_next = (module_word == swcs_pkg::DECO_BUILT_IN);
              end else if (instr_offset == 16'd3 && deco_builtin &&
                           module_word == swcs_pkg::BUILTIN_VIEW_INDEX) begin
                pending_code_next = swcs_pkg::VERD_VIEW_INDEX;
              end
            end
          end
          swcs_pkg::OPC_MEMBER_DECORATE: begin
            if (instr_length >= 16'd5) begin
              if (instr_offset == 16'd3) begin
                deco_builtin_next = (module_word == swcs_pkg::DECO_BUILT_IN);
              end else if (instr_offset == 16'd4 && deco_builtin &&
                           module_word == swcs_pkg::BUILTIN_VIEW_INDEX) begin
                pending_code_next = swcs_pkg::VERD_VIEW_INDEX;
              end
            end
          end
          default: ;
        endcase
      end

      // a zero word count ends the scan before the offset moves
      if (!scan_stopped_next) begin
        if (offset_inc == instr_length_next) begin
          if (pending_code_next != swcs_pkg::VERD_NONE) begin
            found_code_next  = pending_code_next;
            found_width_next = (pending_code_next == swcs_pkg::VERD_INT_WIDTH) ?
                               pending_width_next : 32'd0;
          end
          instr_offset_next  = '0;
          pending_code_next  = swcs_pkg::VERD_NONE;
          pending_width_next = '0;
        end else begin
          instr_offset_next = offset_inc;
        end
      end
    end

    res_valid         = accept && final_word;
    res.verdict       = found_code_next;
    res.bad_int_width = (found_code_next == swcs_pkg::VERD_INT_WIDTH) ?
                        found_width_next : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && final_word)) begin
      header_count  <= '0;
      instr_offset  <= '0;
      instr_length  <= '0;
      instr_opcode  <= '0;
      deco_builtin  <= 1'b0;
      pending_code  <= swcs_pkg::VERD_NONE;
      pending_width <= '0;
      found_code    <= swcs_pkg::VERD_NONE;
      found_width   <= '0;
      scan_stopped  <= 1'b0;
    end else if (accept) begin
      header_count  <= header_count_next;
      instr_offset  <= instr_offset_next;
      instr_length  <= instr_length_next;
      instr_opcode  <= instr_opcode_next;
      deco_builtin  <= deco_builtin_next;
      pending_code  <= pending_code_next;
      pending_width <= pending_width_next;
      found_code    <= found_code_next;
      found_width   <= found_width_next;
      scan_stopped  <= scan_stopped_next;
    end
  end

`ifndef ASSERT_OFF
  a_header_range: assert property (@(posedge clk) disable iff (rst)
    header_count <= swcs_pkg::HEADER_WORDS)
    else $error("header count out of range");

  a_no_scan_in_header: assert property (@(posedge clk) disable iff (rst)
    header_count < swcs_pkg::HEADER_WORDS |->
      instr_offset == 16'd0 && found_code == swcs_pkg::VERD_NONE && !scan_stopped)
    else $error("scan state moved during header");

  a_found_frozen: assert property (@(posedge clk) disable iff (rst)
    found_code != swcs_pkg::VERD_NONE && accept && !final_word |=>
      found_code == $past(found_code))
    else $error("found case changed after first hit");
`endif

endmodule

/* sv/swcs_out_reg.sv */
// ----------------------------------------------------------------------------
// swcs_out_reg
// Result register on the output channel; holds a verdict while stalled.
// ----------------------------------------------------------------------------
module swcs_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_valid,
  input  swcs_pkg::result_t res,
  output logic              hold,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        verdict,
  output logic [31:0]       bad_int_width
);

  swcs_pkg::result_t held;

  assign hold = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!hold) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold && res_valid) begin
      held <= res;
    end
  end

  assign verdict       = held.verdict;
  assign bad_int_width = held.bad_int_width;

endmodule

/* sv/spirv_wgsl_compat_scanner.sv */
// ----------------------------------------------------------------------------
// spirv_wgsl_compat_scanner
// Streams a SPIR-V module one word per request and reports the first
// construct that blocks conversion to WGSL.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): module_word plus final_word, which
//   marks the last word of a module. The five header words are skipped, the
//   rest is split into instructions by the word count in bits 31..16.
//   Output channel (out_valid / out_stall): one verdict per module, given on
//   its final word: 0 none, 1 integer width not 32 (bad_int_width holds it),
//   2 image texel pointer, 3 BuiltIn ViewIndex decoration.
//   Throughput: one word per cycle unless in_stall holds a final word; the
//   scan state updates in a single pass from the accepted word to the result
//   register; the verdict shows in the cycle after the final word is accepted.
//   Stall: while a verdict waits under out_stall, in_stall is raised only for
//   a final word; other words keep streaming. Once the verdict is taken the
//   final word is accepted in the same cycle.
//   Reset: synchronous rst clears the scan state and out_valid, not the held
//   verdict data; scan state also returns to reset after every final word.
// ----------------------------------------------------------------------------
module spirv_wgsl_compat_scanner (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] module_word,
  input  logic        final_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  verdict,
  output logic [31:0] bad_int_width
);

  logic              accept;
  logic              res_valid;
  logic              hold;
  swcs_pkg::result_t res;

  // only a final word needs the result register free
  assign in_stall = hold && final_word;
  assign accept   = in_valid && !in_stall;

  swcs_core u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .module_word (module_word),
    .final_word  (final_word),
    .res_valid   (res_valid),
    .res         (res)
  );

  swcs_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .res_valid     (res_valid),
    .res           (res),
    .hold          (hold),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .verdict       (verdict),
    .bad_int_width (bad_int_width)
  );

`ifndef ASSERT_OFF
  a_final_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && final_word |=> out_valid)
    else $error("final word gave no verdict");

  a_nonfinal_no_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !final_word && !(out_valid && out_stall) |=> !out_valid)
    else $error("verdict without final word");

  a_width_only_for_int: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict != swcs_pkg::VERD_INT_WIDTH |-> bad_int_width == 32'd0)
    else $error("integer width reported with other verdict");
`endif

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for spirv_wgsl_compat_scanner. Streams directed and
// random SPIR-V modules word by word, predicts the verdict of each module in
// a scoreboard and checks every verdict, under several idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned PHASE_WORDS = 375;

  // Scan predictor plus queue of verdicts still owed by the block
  class scan_scoreboard;
    logic [2:0]           hdr_seen;
    logic [15:0]          word_pos;
    logic [15:0]          instr_len;
    logic [15:0]          opcode;
    logic [31:0]          deco_word;
    swcs_pkg::verdict_t   pend_code;
    logic [31:0]          pend_width;
    swcs_pkg::verdict_t   hit_code;
    logic [31:0]          hit_width;
    logic                 halted;
    swcs_pkg::result_t    verdict_q[$];
    int unsigned          mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      hdr_seen   = '0;
      word_pos   = '0;
      instr_len  = '0;
      opcode     = '0;
      deco_word  = '0;
      pend_code  = swcs_pkg::VERD_NONE;
      pend_width = '0;
      hit_code   = swcs_pkg::VERD_NONE;
      hit_width  = '0;
      halted     = 1'b0;
    endfunction

    function void note_word(logic [31:0] w, logic last);
      swcs_pkg::result_t res;
      if (hdr_seen < swcs_pkg::HEADER_WORDS) begin
        hdr_seen++;
      end else if (!halted && hit_code == swcs_pkg::VERD_NONE) begin
        if (word_pos == 16'd0) begin
          instr_len = w[31:16];
          opcode    = w[15:0];
          if (instr_len == 16'd0) begin
            halted = 1'b1;
          end else begin
            pend_code  = (opcode == swcs_pkg::OPC_IMAGE_TEXEL_POINTER) ?
                         swcs_pkg::VERD_IMAGE_ATOMIC : swcs_pkg::VERD_NONE;
            pend_width = '0;
            deco_word  = '0;
          end
        end else if (opcode == swcs_pkg::OPC_TYPE_INT && instr_len >= 16'd3) begin
          if (word_pos == 16'd2 && w != swcs_pkg::INT_WIDTH_OK) begin
            pend_code  = swcs_pkg::VERD_INT_WIDTH;
            pend_width = w;
          end
        end else if (opcode == swcs_pkg::OPC_DECORATE && instr_len >= 16'd4) begin
          if (word_pos == 16'd2)
            deco_word = w;
          else if (word_pos == 16'd3 && deco_word == swcs_pkg::DECO_BUILT_IN &&
                   w == swcs_pkg::BUILTIN_VIEW_INDEX)
            pend_code = swcs_pkg::VERD_VIEW_INDEX;
        end else if (opcode == swcs_pkg::OPC_MEMBER_DECORATE && instr_len >= 16'd5) begin
          if (word_pos == 16'd3)
            deco_word = w;
          else if (word_pos == 16'd4 && deco_word == swcs_pkg::DECO_BUILT_IN &&
                   w == swcs_pkg::BUILTIN_VIEW_INDEX)
            pend_code = swcs_pkg::VERD_VIEW_INDEX;
        end
        // zero word count ends the scan before any position update
        if (!halted) begin
          word_pos++;
          if (word_pos == instr_len) begin
            if (pend_code != swcs_pkg::VERD_NONE) begin
              hit_code  = pend_code;
              hit_width = (pend_code == swcs_pkg::VERD_INT_WIDTH) ? pend_width : '0;
            end
            word_pos   = '0;
            pend_code  = swcs_pkg::VERD_NONE;
            pend_width = '0;
          end
        end
      end
      if (last) begin
        res.verdict       = hit_code;
        res.bad_int_width = (hit_code == swcs_pkg::VERD_INT_WIDTH) ? hit_width : '0;
        verdict_q.insert(verdict_q.size(), res);
        restart();
      end
    endfunction

    function void log_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endfunction

    function void check_result(logic [1:0] got_verdict, logic [31:0] got_width);
      swcs_pkg::result_t want;
      if (verdict_q.size() == 0) begin
        log_mismatch($sformatf("verdict %0d width 0x%08h with no module pending",
                               got_verdict, got_width));
        return;
      end
      want = verdict_q.pop_front();
      if (got_verdict !== want.verdict || got_width !== want.bad_int_width)
        log_mismatch($sformatf("verdict exp %0d got %0d, width exp 0x%08h got 0x%08h",
                               want.verdict, got_verdict, want.bad_int_width, got_width));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] module_word = '0;
  logic        final_word = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  verdict;
  logic [31:0] bad_int_width;

  scan_scoreboard scoreboard = new();
  logic [31:0]    module_buf[$];
  int unsigned    send_gap_pct = 0;
  int unsigned    stall_pct = 0;
  int unsigned    gap_tab[4] = '{0, 65, 0, 28};
  int unsigned    stall_tab[4] = '{0, 0, 65, 28};
  int unsigned    quiet_cycles = 0;

  spirv_wgsl_compat_scanner dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .module_word  (module_word),
    .final_word   (final_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .verdict      (verdict),
    .bad_int_width(bad_int_width)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void append_word(logic [31:0] w);
    module_buf.insert(module_buf.size(), w);
  endfunction

  function automatic void add_header();
    repeat (5) append_word($urandom());
  endfunction

  // instruction of len words; offsets 2..4 take the given words, the rest random
  function automatic void add_instr(logic [15:0] len, logic [15:0] op,
                                    logic [31:0] at2, logic [31:0] at3, logic [31:0] at4);
    append_word({len, op});
    for (int i = 1; i < len; i++) begin
      case (i)
        2:       append_word(at2);
        3:       append_word(at3);
        4:       append_word(at4);
        default: append_word($urandom());
      endcase
    end
  endfunction

  function automatic void build_random_module();
    int unsigned pick;
    logic [31:0] deco;
    logic [31:0] val;
    logic [31:0] wid;
    module_buf.delete();
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 5)) append_word($urandom());
      return;
    end
    add_header();
    repeat ($urandom_range(0, 6)) begin
      pick = $urandom_range(0, 19);
      deco = ($urandom_range(99) < 70) ? swcs_pkg::DECO_BUILT_IN :
             32'($urandom_range(0, 15));
      val  = ($urandom_range(99) < 70) ? swcs_pkg::BUILTIN_VIEW_INDEX :
             32'($urandom_range(4436, 4444));
      case ($urandom_range(0, 5))
        0:       wid = 32'd8;
        1:       wid = 32'd16;
        4:       wid = 32'd64;
        5:       wid = $urandom();
        default: wid = swcs_pkg::INT_WIDTH_OK;
      endcase
      if (pick < 3)
        add_instr(16'($urandom_range(2, 5)), swcs_pkg::OPC_TYPE_INT, wid, $urandom(),
                  $urandom());
      else if (pick == 3)
        add_instr(16'($urandom_range(1, 5)), swcs_pkg::OPC_IMAGE_TEXEL_POINTER, $urandom(),
                  $urandom(), $urandom());
      else if (pick < 7)
        add_instr(16'($urandom_range(3, 6)), swcs_pkg::OPC_DECORATE, deco, val, $urandom());
      else if (pick < 10)
        add_instr(16'($urandom_range(4, 7)), swcs_pkg::OPC_MEMBER_DECORATE, $urandom(), deco,
                  val);
      else if (pick < 17)
        add_instr(16'($urandom_range(1, 4)), 16'($urandom_range(0, 100)), $urandom(),
                  $urandom(), $urandom());
      else if (pick == 17)
        append_word($urandom());   // arbitrary length, usually swallows the rest
      else
        append_word({16'h0000, 16'($urandom())});
    end
    // cut the tail so the last instruction may end incomplete
    if (module_buf.size() > 5 && $urandom_range(99) < 20)
      repeat ($urandom_range(1, 3))
        if (module_buf.size() > 1) void'(module_buf.pop_back());
  endfunction

  task automatic send_word(logic [31:0] w, logic last);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    module_word <= w;
    final_word  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    scoreboard.note_word(w, last);
  endtask

  task automatic send_module();
    foreach (module_buf[i]) send_word(module_buf[i], i == module_buf.size() - 1);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) scoreboard.check_result(verdict, bad_int_width);
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    int unsigned phase_words;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // module ending in its first header word
    module_buf = '{32'hFFFF_FFFF};
    send_module();
    // header only, extreme words
    module_buf = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0};
    send_module();
    // 64-bit integer
    module_buf.delete();
    add_header();
    add_instr(16'd3, swcs_pkg::OPC_TYPE_INT, 32'd64, 32'd0, 32'd0);
    send_module();
    // 32-bit integer passes, then the widest width
    module_buf.delete();
    add_header();
    add_instr(16'd4, swcs_pkg::OPC_TYPE_INT, swcs_pkg::INT_WIDTH_OK, 32'd0, 32'd0);
    add_instr(16'd3, swcs_pkg::OPC_TYPE_INT, 32'hFFFF_FFFF, 32'd0, 32'd0);
    send_module();
    // integer too short for a width word, then a one-word texel pointer
    module_buf.delete();
    add_header();
    add_instr(16'd2, swcs_pkg::OPC_TYPE_INT, 32'd0, 32'd0, 32'd0);
    add_instr(16'd1, swcs_pkg::OPC_IMAGE_TEXEL_POINTER, 32'd0, 32'd0, 32'd0);
    send_module();
    // near-miss decorate, then ViewIndex by member decoration
    module_buf.delete();
    add_header();
    add_instr(16'd4, swcs_pkg::OPC_DECORATE, swcs_pkg::DECO_BUILT_IN,
              swcs_pkg::BUILTIN_VIEW_INDEX + 32'd1, 32'd0);
    add_instr(16'd5, swcs_pkg::OPC_MEMBER_DECORATE, 32'd0, swcs_pkg::DECO_BUILT_IN,
              swcs_pkg::BUILTIN_VIEW_INDEX);
    send_module();
    // ViewIndex by decoration
    module_buf.delete();
    add_header();
    add_instr(16'd4, swcs_pkg::OPC_DECORATE, swcs_pkg::DECO_BUILT_IN,
              swcs_pkg::BUILTIN_VIEW_INDEX, 32'd0);
    send_module();
    // zero word count stops the scan before a texel pointer
    module_buf.delete();
    add_header();
    append_word({16'h0000, swcs_pkg::OPC_TYPE_INT});
    add_instr(16'd1, swcs_pkg::OPC_IMAGE_TEXEL_POINTER, 32'd0, 32'd0, 32'd0);
    send_module();
    // texel pointer cut off by the final word
    module_buf.delete();
    add_header();
    add_instr(16'd3, swcs_pkg::OPC_IMAGE_TEXEL_POINTER, 32'd0, 32'd0, 32'd0);
    void'(module_buf.pop_back());
    send_module();
    // first case wins; words after it are ignored
    module_buf.delete();
    add_header();
    add_instr(16'd3, swcs_pkg::OPC_TYPE_INT, 32'd16, 32'd0, 32'd0);
    add_instr(16'd1, swcs_pkg::OPC_IMAGE_TEXEL_POINTER, 32'd0, 32'd0, 32'd0);
    append_word(32'h0000_0000);
    send_module();

    for (int ph = 0; ph < 4; ph++) begin
      send_gap_pct = gap_tab[ph];
      stall_pct    = stall_tab[ph];
      phase_words  = 0;
      while (phase_words < PHASE_WORDS) begin
        build_random_module();
        send_module();
        phase_words += module_buf.size();
      end
    end

    in_valid <= 1'b0;
    while (scoreboard.verdict_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (scoreboard.mismatches == 0 && scoreboard.verdict_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

/* spirv_wgsl_compat_scanner.f */
sv/swcs_pkg.sv
sv/swcs_core.sv
sv/swcs_out_reg.sv
sv/spirv_wgsl_compat_scanner.sv
tb/tb_top.sv
